// ===== rtl/ttvc_pkg.sv =====
`timescale 1ns / 1ps
// ttvc_pkg: shared types, codes and constants of the tag tracking velocity controller
// also holds the sine table angle constant; no dependencies

package ttvc_pkg;

	// control law selected per word
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_FRONT = 2'd1;
	localparam logic [1:0] MODE_TRACK = 2'd2;
	localparam logic [1:0] MODE_ZERO  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_GAIN_X     = 3'd0;
	localparam logic [2:0] REG_GAIN_Y     = 3'd1;
	localparam logic [2:0] REG_GAIN_TIME  = 3'd2;
	localparam logic [2:0] REG_GAIN_Z     = 3'd3;
	localparam logic [2:0] REG_GAIN_YAW   = 3'd4;
	localparam logic [2:0] REG_ALT_TARGET = 3'd5;
	localparam logic [2:0] REG_PLANAR_LIM = 3'd6;

	localparam logic [15:0] LIM_03 = 16'd9830;          // 0.3 in Q1.15
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// controls that go with one product into the scaler
	typedef struct packed {
		logic zero;   // force the command to zero
		logic track;  // bottom law scaling, else front law scaling
		logic neg;    // sign of the product
	} scale_ctl_t;

	// per-word pipeline contents
	typedef struct packed {
		logic [1:0]         mode;
		logic               yaw_lo;
		logic               yaw_hi;
		logic signed [12:0] e;
		logic signed [13:0] dz;
		logic signed [9:0]  dh;
		logic [15:0]        dt;
		logic signed [14:0] ax;
		logic signed [14:0] ay;
		logic signed [16:0] dx64;
		logic signed [16:0] dy64;
		logic [36:0]        prod_z;
		logic               neg_z;
		logic [32:0]        prod_yaw;
		logic               neg_yaw;
		logic [39:0]        tdt;
		logic [33:0]        gx1000;
		logic [33:0]        gy1000;
		logic [9:0]         h;
		logic signed [15:0] vz;
		logic signed [15:0] yaw;
		logic signed [41:0] cfront;
		logic [40:0]        cx;
		logic [40:0]        cy;
		logic [25:0]        hsx;
		logic               negsx;
		logic [25:0]        hsy;
		logic               negsy;
		logic signed [18:0] ex;
		logic signed [18:0] ey;
	} pipe_t;

endpackage

// ===== rtl/tag_tracking_velocity_controller_core.sv =====
`timescale 1ns / 1ps
// tag_tracking_velocity_controller_core: top level, register file and main pipeline
// depends on ttvc_pkg, ttvc_sine, ttvc_scale
//
//  channel  | handshake               | word
//  ---------+-------------------------+--------------------------------------------
//  input    | in_valid / in_ready     | tag count, camera kind, tag pose, altitude,
//           |                         | tilt angles, elapsed time
//  output   | out_valid / out_ready   | speed_x, speed_y, speed_z, yaw_rate
//  config   | cfg_we                  | cfg_index, cfg_data, no wait
//
// ten register stages, one word per cycle while the output stage is not stalled
// the whole pipe advances together when the output stage is empty or taken
// in_ready is low only while a result waits in the output stage
// reset clears the valid bits and loads the register defaults

module tag_tracking_velocity_controller_core #(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         tag_count,
	input  logic [1:0]         camera_kind,
	input  logic [9:0]         tag_x,
	input  logic [9:0]         tag_y,
	input  logic [11:0]        tag_range,
	input  logic [8:0]         tag_heading,
	input  logic [12:0]        altitude,
	input  logic signed [14:0] tilt_x_angle,
	input  logic signed [14:0] tilt_y_angle,
	input  logic [15:0]        elapsed_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] speed_x,
	output logic signed [15:0] speed_y,
	output logic signed [15:0] speed_z,
	output logic signed [15:0] yaw_rate,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);
	import ttvc_pkg::*;

	// configuration registers
	logic [23:0] gain_x_q, gain_y_q, gain_time_q, gain_z_q, gain_yaw_q;
	logic [12:0] alt_target_q;
	logic [14:0] plim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q     <= 24'd1845;
			gain_y_q     <= 24'd1845;
			gain_time_q  <= 24'd184549;
			gain_z_q     <= 24'd8389;
			gain_yaw_q   <= 24'd419430;
			alt_target_q <= 13'd1850;
			plim_q       <= 15'd13107;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_X:     gain_x_q     <= cfg_data;
				REG_GAIN_Y:     gain_y_q     <= cfg_data;
				REG_GAIN_TIME:  gain_time_q  <= cfg_data;
				REG_GAIN_Z:     gain_z_q     <= cfg_data;
				REG_GAIN_YAW:   gain_yaw_q   <= cfg_data;
				REG_ALT_TARGET: alt_target_q <= cfg_data[12:0];
				REG_PLANAR_LIM: plim_q       <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// global advance: a stall freezes every stage at once
	logic adv;
	logic [10:1] vld;
	assign adv       = out_ready | ~vld[10];
	assign in_ready  = adv;
	assign out_valid = vld[10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[9:1], in_valid};
		end
	end

	pipe_t p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7, p_s8, p_s9, p_s10;
	pipe_t n_s1, n_s2, n_s3, n_s6, n_s7;

	// stage 1: mode decode and input differences
	always_comb begin
		logic signed [10:0] dxp;
		logic signed [10:0] dyp;
		n_s1 = p_s1;
		if (tag_count == 4'd0) begin
			n_s1.mode = MODE_NONE;
		end else if (tag_count == 4'd1 && camera_kind == 2'd0) begin
			n_s1.mode = MODE_FRONT;
		end else if (tag_count > 4'd1 || camera_kind == 2'd1) begin
			n_s1.mode = MODE_TRACK;
		end else begin
			n_s1.mode = MODE_ZERO;
		end
		n_s1.yaw_lo = tag_x < 10'd450;
		n_s1.yaw_hi = tag_x > 10'd550;
		n_s1.e      = 13'sd150 - $signed({1'b0, tag_range});
		n_s1.dz     = $signed({1'b0, alt_target_q}) - $signed({1'b0, altitude});
		n_s1.dh     = $signed({1'b0, tag_heading}) - 10'sd90;
		n_s1.dt     = elapsed_ms;
		n_s1.ax     = tilt_x_angle;
		n_s1.ay     = tilt_y_angle;
		dxp         = 11'sd500 - $signed({1'b0, tag_x});
		dyp         = 11'sd500 - $signed({1'b0, tag_y});
		n_s1.dx64   = {dxp, 6'b0};
		n_s1.dy64   = {dyp, 6'b0};
	end

	// stage 2: gain products, time coefficient, scaled altitude target
	always_comb begin
		logic [12:0] mz;
		logic [8:0]  mh;
		logic [25:0] hp;
		n_s2 = p_s1;
		mz = p_s1.dz[13] ? 13'(-p_s1.dz) : 13'(p_s1.dz);
		mh = p_s1.dh[9] ? 9'(-p_s1.dh) : 9'(p_s1.dh);
		n_s2.prod_z   = 37'(gain_z_q) * 37'(mz);
		n_s2.neg_z    = p_s1.dz[13];
		n_s2.prod_yaw = 33'(gain_yaw_q) * 33'(mh);
		n_s2.neg_yaw  = p_s1.dh[9];
		n_s2.tdt      = 40'(gain_time_q) * 40'(p_s1.dt);
		n_s2.gx1000   = 34'(gain_x_q) * 34'd1000;
		n_s2.gy1000   = 34'(gain_y_q) * 34'd1000;
		// altitude target / 10 through the reciprocal 6554 / 2^16
		hp            = 26'(alt_target_q) * 26'd6554;
		n_s2.h        = hp[25:16];
	end

	// stage 3: vertical and yaw commands finish here, planar coefficients formed
	always_comb begin
		logic [36:0] sz;
		logic [32:0] sy;
		logic [15:0] cz;
		logic [15:0] cy;
		logic signed [15:0] vz_cmd;
		logic signed [15:0] yaw_trk;
		n_s3 = p_s2;
		sz = p_s2.prod_z + 37'd256;
		sy = p_s2.prod_yaw + 33'd256;
		cz = (sz[36:9] > 28'(LIM_03)) ? LIM_03 : sz[24:9];
		cy = (sy[32:9] > 24'(LIM_03)) ? LIM_03 : sy[24:9];
		vz_cmd  = p_s2.neg_z ? -$signed(cz) : $signed(cz);
		yaw_trk = p_s2.neg_yaw ? -$signed(cy) : $signed(cy);
		n_s3.vz  = '0;
		n_s3.yaw = '0;
		case (p_s2.mode)
			MODE_NONE: n_s3.vz = vz_cmd;
			MODE_FRONT: begin
				// window step on the image x coordinate
				if (p_s2.yaw_lo) begin
					n_s3.yaw = -$signed(LIM_03);
				end else if (p_s2.yaw_hi) begin
					n_s3.yaw = $signed(LIM_03);
				end
			end
			MODE_TRACK: begin
				n_s3.vz  = vz_cmd;
				n_s3.yaw = yaw_trk;
			end
			default: ;
		endcase
		n_s3.cfront = $signed({2'b0, p_s2.tdt}) - $signed({8'b0, p_s2.gx1000});
		n_s3.cx     = 41'(p_s2.tdt) + 41'(p_s2.gx1000);
		n_s3.cy     = 41'(p_s2.tdt) + 41'(p_s2.gy1000);
	end

	// tilt sines run alongside stages 2 to 5
	logic [15:0] smx_s5, smy_s5;
	logic        snx_s5, sny_s5;

	ttvc_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sine_x (
		.clk   (clk),
		.en    (adv),
		.angle (p_s1.ax),
		.mag   (smx_s5),
		.neg   (snx_s5)
	);

	ttvc_sine #(.DEPTH(SINE_TABLE_DEPTH)) u_sine_y (
		.clk   (clk),
		.en    (adv),
		.angle (p_s1.ay),
		.mag   (smy_s5),
		.neg   (sny_s5)
	);

	// stage 6: height times tilt sine
	always_comb begin
		n_s6 = p_s5;
		n_s6.hsx   = 26'(p_s5.h) * 26'(smx_s5);
		n_s6.negsx = snx_s5;
		n_s6.hsy   = 26'(p_s5.h) * 26'(smy_s5);
		n_s6.negsy = sny_s5;
	end

	// stage 7: tilt-corrected pixel errors in 1/64 pixel
	always_comb begin
		logic [25:0] rx;
		logic [25:0] ry;
		logic signed [18:0] tx;
		logic signed [18:0] ty;
		n_s7 = p_s6;
		rx = p_s6.hsx + 26'd256;
		ry = p_s6.hsy + 26'd256;
		tx = $signed({2'b0, rx[25:9]});
		ty = $signed({2'b0, ry[25:9]});
		n_s7.ex = 19'(p_s6.dx64) + (p_s6.negsx ? -tx : tx);
		n_s7.ey = 19'(p_s6.dy64) + (p_s6.negsy ? -ty : ty);
	end

	// stage 8: error times coefficient, magnitude and sign
	logic [58:0] prodx_s8, prody_s8;
	scale_ctl_t  ctlx_s8, ctly_s8;

	always_ff @(posedge clk) begin
		logic [17:0] ax;
		logic [40:0] bx;
		logic [17:0] ay;
		logic        front;
		logic        track;
		if (adv) begin
			front = p_s7.mode == MODE_FRONT;
			track = p_s7.mode == MODE_TRACK;
			if (front) begin
				ax = 18'(p_s7.e[12] ? 13'(-p_s7.e) : 13'(p_s7.e));
				bx = p_s7.cfront[41] ? 41'(-p_s7.cfront) : 41'(p_s7.cfront);
				ctlx_s8.neg <= p_s7.e[12] ^ p_s7.cfront[41];
			end else begin
				ax = p_s7.ex[18] ? 18'(-p_s7.ex) : 18'(p_s7.ex);
				bx = p_s7.cx;
				ctlx_s8.neg <= p_s7.ex[18];
			end
			ay = p_s7.ey[18] ? 18'(-p_s7.ey) : 18'(p_s7.ey);
			prodx_s8 <= 59'(ax) * 59'(bx);
			prody_s8 <= 59'(ay) * 59'(p_s7.cy);
			ctlx_s8.zero  <= !(front || track);
			ctlx_s8.track <= track;
			ctly_s8.zero  <= !track;
			ctly_s8.track <= 1'b1;
			ctly_s8.neg   <= p_s7.ey[18];
		end
	end

	// stages 9 and 10: round, divide, clamp to the planar limit
	ttvc_scale u_scale_x (
		.clk   (clk),
		.en    (adv),
		.prod  (prodx_s8),
		.ctl   (ctlx_s8),
		.plim  (plim_q),
		.speed (speed_x)
	);

	ttvc_scale u_scale_y (
		.clk   (clk),
		.en    (adv),
		.prod  (prody_s8),
		.ctl   (ctly_s8),
		.plim  (plim_q),
		.speed (speed_y)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1  <= n_s1;
			p_s2  <= n_s2;
			p_s3  <= n_s3;
			p_s4  <= p_s3;
			p_s5  <= p_s4;
			p_s6  <= n_s6;
			p_s7  <= n_s7;
			p_s8  <= p_s7;
			p_s9  <= p_s8;
			p_s10 <= p_s9;
		end
	end

	assign speed_z  = p_s10.vz;
	assign yaw_rate = p_s10.yaw;

endmodule

// ===== rtl/ttvc_sine.sv =====
`timescale 1ns / 1ps
// ttvc_sine: four-stage sine of an angle in 1/64 degree, quarter-wave table
// depends on ttvc_pkg

module ttvc_sine #(
	parameter int DEPTH = 256
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [14:0] angle,
	output logic [15:0]        mag,
	output logic               neg
);
	import ttvc_pkg::*;

	localparam int IW = $clog2(DEPTH + 1);
	localparam int PW = 13 + $clog2(DEPTH + 1);
	localparam int VW = PW - 7;
	localparam int XW = VW + 19;
	localparam int DW = XW - 24;

	logic [15:0] rom [0:DEPTH];

	// table entries in Q1.15, integer Taylor series to x^15 on a Q30 angle
	for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
		localparam longint unsigned XK = HALF_PI_Q30 * longint'(k) / longint'(DEPTH);
		localparam longint unsigned X2 = (XK * XK) >> 30;
		localparam longint unsigned T1 = ((XK * X2) >> 30) / 64'd6;
		localparam longint unsigned T2 = ((T1 * X2) >> 30) / 64'd20;
		localparam longint unsigned T3 = ((T2 * X2) >> 30) / 64'd42;
		localparam longint unsigned T4 = ((T3 * X2) >> 30) / 64'd72;
		localparam longint unsigned T5 = ((T4 * X2) >> 30) / 64'd110;
		localparam longint unsigned T6 = ((T5 * X2) >> 30) / 64'd156;
		localparam longint unsigned T7 = ((T6 * X2) >> 30) / 64'd210;
		localparam longint SUM = longint'(XK) - longint'(T1) + longint'(T2)
			- longint'(T3) + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
		localparam longint unsigned QR = (SUM < 0) ? 64'd0
			: ($unsigned(SUM) + 64'd16384) >> 15;
		assign rom[k] = (QR > 64'd32768) ? 16'h8000 : 16'(QR);
	end

	logic [1:0]    q_s1, q_s2, q_s3;
	logic [12:0]   r_s1;
	logic [VW-1:0] v_s2;
	logic [IW-1:0] idx_s3;

	// reduce to quadrant and remainder
	always_ff @(posedge clk) begin
		logic signed [15:0] ae;
		logic [14:0]        m;
		if (en) begin
			ae = {angle[14], angle} + 16'sd23040;
			m = angle[14] ? ae[14:0] : angle;
			if (m >= 15'd17280) begin
				q_s1 <= 2'd3;
				r_s1 <= 13'(m - 15'd17280);
			end else if (m >= 15'd11520) begin
				q_s1 <= 2'd2;
				r_s1 <= 13'(m - 15'd11520);
			end else if (m >= 15'd5760) begin
				q_s1 <= 2'd1;
				r_s1 <= 13'(m - 15'd5760);
			end else begin
				q_s1 <= 2'd0;
				r_s1 <= m[12:0];
			end
		end
	end

	// scale remainder to table steps, first part of the divide by 5760
	always_ff @(posedge clk) begin
		logic [PW-1:0] p;
		if (en) begin
			p = PW'(r_s1) * PW'(DEPTH) + PW'(2880);
			v_s2 <= p[PW-1:7];
			q_s2 <= q_s1;
		end
	end

	// divide by 45 through the reciprocal, then mirror odd quadrants
	always_ff @(posedge clk) begin
		logic [XW-1:0] p;
		logic [DW-1:0] d;
		logic [IW-1:0] i;
		if (en) begin
			p = XW'(v_s2) * XW'(372828);
			d = p[XW-1:24];
			i = (d > DW'(DEPTH)) ? IW'(DEPTH) : d[IW-1:0];
			idx_s3 <= q_s2[0] ? IW'(DEPTH) - i : i;
			q_s3 <= q_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag <= rom[idx_s3];
			neg <= q_s3[1];
		end
	end

endmodule

// ===== rtl/ttvc_scale.sv =====
`timescale 1ns / 1ps
// ttvc_scale: two-stage rounding divide by 512000 or 32768000 and clamp
// depends on ttvc_pkg

module ttvc_scale (
	input  logic                    clk,
	input  logic                    en,
	input  logic [58:0]             prod,
	input  ttvc_pkg::scale_ctl_t    ctl,
	input  logic [14:0]             plim,
	output logic signed [15:0]      speed
);
	import ttvc_pkg::*;

	logic [22:0] v_s1;
	scale_ctl_t  ctl_s1;

	// round, take off the power of two and saturate ahead of the divide by 125
	always_ff @(posedge clk) begin
		logic [59:0] sum;
		logic [47:0] v;
		if (en) begin
			if (ctl.track) begin
				sum = {1'b0, prod} + 60'd16384000;
				v = 48'(sum >> 18);
			end else begin
				sum = {1'b0, prod} + 60'd256000;
				v = sum[59:12];
			end
			v_s1 <= (v > 48'd4096000) ? 23'd4096000 : v[22:0];
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		logic [46:0] p;
		logic [16:0] q;
		logic [15:0] c;
		if (en) begin
			p = 47'(v_s1) * 47'd8589935;
			q = p[46:30];
			c = (q > 17'(plim)) ? 16'(plim) : q[15:0];
			if (ctl_s1.zero) begin
				speed <= '0;
			end else begin
				speed <= ctl_s1.neg ? -$signed(c) : $signed(c);
			end
		end
	end

endmodule

// ===== dv/ttvc_checker.sv =====
`timescale 1ns / 1ps
// ttvc_checker: watches the sample and command channels of the velocity controller,
// predicts each command word and compares it; depends on ttvc_pkg

module ttvc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [3:0]         tag_count,
	input  logic [1:0]         camera_kind,
	input  logic [9:0]         tag_x,
	input  logic [9:0]         tag_y,
	input  logic [11:0]        tag_range,
	input  logic [8:0]         tag_heading,
	input  logic [12:0]        altitude,
	input  logic signed [14:0] tilt_x_angle,
	input  logic signed [14:0] tilt_y_angle,
	input  logic [15:0]        elapsed_ms,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] speed_x,
	input  logic signed [15:0] speed_y,
	input  logic signed [15:0] speed_z,
	input  logic signed [15:0] yaw_rate,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output int                 fail_count,
	output int                 pending
);
	import ttvc_pkg::*;

	localparam int DEPTH = 256;
	localparam longint SAT = 9830;

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] vz;
		logic signed [15:0] yaw;
	} command_t;

	command_t cmd_queue[$];
	longint sine_lut[DEPTH + 1];
	longint g_x, g_y, g_t, g_z, g_yaw, alt_tgt, p_lim;

	// quarter-wave table, integer Taylor series to x^15
	initial begin
		longint unsigned x, x2, term, q;
		longint sum;
		for (int k = 0; k <= DEPTH; k++) begin
			x = 64'd1686629713 * k / DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) sum -= longint'(term);
				else sum += longint'(term);
			end
			if (sum < 0) sum = 0;
			q = (longint'(sum) + 16384) >> 15;
			if (q > 32768) q = 32768;
			sine_lut[k] = longint'(q);
		end
	end

	// round half away from zero
	function automatic longint round_div(longint num, longint den);
		longint mag;
		mag = (num < 0) ? -num : num;
		mag = (mag + den / 2) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	function automatic longint sat_to(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// sine in Q1.15 of an angle in 1/64 degree
	function automatic longint sine_of(longint a);
		longint m, quad, rem, idx, s;
		m = a % 23040;
		if (m < 0) m += 23040;
		quad = m / 5760;
		rem = m % 5760;
		idx = (rem * DEPTH + 2880) / 5760;
		if (idx > DEPTH) idx = DEPTH;
		if (quad % 2 == 1) idx = DEPTH - idx;
		s = sine_lut[idx];
		return (quad >= 2) ? -s : s;
	endfunction

	function automatic command_t velocity_law();
		command_t c;
		longint vx, vy, vz, yw, vz_alt, err, coef, h, ex, ey, cx, cy;
		vx = 0; vy = 0; vz = 0; yw = 0;
		vz_alt = sat_to(round_div(g_z * (alt_tgt - longint'(altitude)), 512), SAT);
		if (tag_count == 0) begin
			vz = vz_alt;
		end else if (tag_count == 1 && camera_kind == 2'd0) begin
			err = 150 - longint'(tag_range);
			coef = g_t * longint'(elapsed_ms) - g_x * 1000;
			vx = sat_to(round_div(err * coef, 512000), p_lim);
			if (tag_x < 450) yw = -SAT;
			else if (tag_x > 550) yw = SAT;
		end else if (tag_count > 1 || camera_kind == 2'd1) begin
			h = alt_tgt / 10;
			ex = (500 - longint'(tag_x)) * 64
				+ round_div(h * sine_of(longint'(tilt_x_angle)), 512);
			ey = (500 - longint'(tag_y)) * 64
				+ round_div(h * sine_of(longint'(tilt_y_angle)), 512);
			cx = g_x * 1000 + g_t * longint'(elapsed_ms);
			cy = g_y * 1000 + g_t * longint'(elapsed_ms);
			vx = sat_to(round_div(ex * cx, 32768000), p_lim);
			vy = sat_to(round_div(ey * cy, 32768000), p_lim);
			vz = vz_alt;
			yw = sat_to(round_div(g_yaw * (longint'(tag_heading) - 90), 512), SAT);
		end
		c.vx = vx[15:0]; c.vy = vy[15:0]; c.vz = vz[15:0]; c.yaw = yw[15:0];
		return c;
	endfunction

	assign pending = cmd_queue.size();

	always @(posedge clk or negedge arst_n) begin
		command_t want;
		if (!arst_n) begin
			g_x <= 1845; g_y <= 1845; g_t <= 184549; g_z <= 8389;
			g_yaw <= 419430; alt_tgt <= 1850; p_lim <= 13107;
			fail_count <= 0;
			cmd_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN_X:     g_x <= cfg_data;
					REG_GAIN_Y:     g_y <= cfg_data;
					REG_GAIN_TIME:  g_t <= cfg_data;
					REG_GAIN_Z:     g_z <= cfg_data;
					REG_GAIN_YAW:   g_yaw <= cfg_data;
					REG_ALT_TARGET: alt_tgt <= cfg_data[12:0];
					REG_PLANAR_LIM: p_lim <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) cmd_queue.push_back(velocity_law());
			if (out_valid && out_ready) begin
				if (cmd_queue.size() == 0) begin
					$error("command word with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					want = cmd_queue.pop_front();
					if (speed_x !== want.vx || speed_y !== want.vy ||
							speed_z !== want.vz || yaw_rate !== want.yaw) begin
						if (speed_x !== want.vx)
							$error("speed_x expected %0d got %0d", want.vx, speed_x);
						if (speed_y !== want.vy)
							$error("speed_y expected %0d got %0d", want.vy, speed_y);
						if (speed_z !== want.vz)
							$error("speed_z expected %0d got %0d", want.vz, speed_z);
						if (yaw_rate !== want.yaw)
							$error("yaw_rate expected %0d got %0d", want.yaw, yaw_rate);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== dv/tb_tag_tracking_velocity_controller_core.sv =====
`timescale 1ns / 1ps
// tb_tag_tracking_velocity_controller_core: stimulus and verdict for the controller core
// depends on ttvc_pkg, the core RTL and ttvc_checker

module tb_tag_tracking_velocity_controller_core;
	import ttvc_pkg::*;

	localparam int RANDOM_WORDS = 1500;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] tag_count = '0;
	logic [1:0] camera_kind = '0;
	logic [9:0] tag_x = '0;
	logic [9:0] tag_y = '0;
	logic [11:0] tag_range = '0;
	logic [8:0] tag_heading = '0;
	logic [12:0] altitude = '0;
	logic signed [14:0] tilt_x_angle = '0;
	logic signed [14:0] tilt_y_angle = '0;
	logic [15:0] elapsed_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] speed_x, speed_y, speed_z, yaw_rate;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	int fail_count, pending;
	int idle_cycles;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	tag_tracking_velocity_controller_core DUT (.*);
	ttvc_checker u_checker (.*);

	// watchdog: cycles in which neither channel moves a word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("tb_tag_tracking_velocity_controller_core: done, errors");
			$finish;
		end
	end

	// receiver: random stall before taking each command word, some stretches with none
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one word through the handshake; valid stays up when back-to-back
	task automatic send_sample(input logic [3:0] cnt, input logic [1:0] kind,
			input logic [9:0] px, input logic [9:0] py, input logic [11:0] rng,
			input logic [8:0] hdg, input logic [12:0] alt,
			input logic [14:0] tx, input logic [14:0] ty, input logic [15:0] ms,
			input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		tag_count <= cnt; camera_kind <= kind; tag_x <= px; tag_y <= py;
		tag_range <= rng; tag_heading <= hdg; altitude <= alt;
		tilt_x_angle <= tx; tilt_y_angle <= ty; elapsed_ms <= ms;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic random_sample(input int gap);
		logic [3:0] cnt;
		logic [14:0] tx, ty;
		int pick;
		pick = $urandom_range(0, 9);
		// mostly tracked samples, some front, none and unknown camera
		cnt = (pick < 5) ? 4'd1 : (pick < 7) ? 4'($urandom_range(2, 15)) :
			(pick < 8) ? 4'd0 : 4'($urandom);
		tx = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23040) - 11520);
		ty = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23040) - 11520);
		send_sample(cnt, ($urandom_range(0, 4) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1)),
			($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 1000)),
			($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 1000)),
			12'($urandom), 9'($urandom), 13'($urandom), tx, ty,
			($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 200)) : 16'($urandom), gap);
	endtask

	// wait for the pipe to drain before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic random_phase(input int words);
		int gap;
		for (int i = 0; i < words; i++) begin
			gap = (i % 200 < 40) ? 0 : $urandom_range(0, 6);
			random_sample(gap);
		end
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every law, window edges, field extremes
		send_sample(4'd0, 2'd0, 10'd500, 10'd500, 12'd0, 9'd0, 13'd0, '0, '0, '0, 0);
		send_sample(4'd0, 2'd0, 10'd0, 10'd0, 12'd0, 9'd0, 13'h1FFF, '0, '0, '0, 0);
		send_sample(4'd1, 2'd0, 10'd449, 10'd0, 12'd0, 9'd0, 13'd0, '0, '0, 16'd0, 0);
		send_sample(4'd1, 2'd0, 10'd450, 10'd0, 12'd150, 9'd0, 13'd0, '0, '0, 16'd10, 0);
		send_sample(4'd1, 2'd0, 10'd550, 10'd0, 12'd4095, 9'd0, 13'd0, '0, '0, 16'hFFFF, 1);
		send_sample(4'd1, 2'd0, 10'd551, 10'd0, 12'd300, 9'd0, 13'd0, '0, '0, 16'd99, 0);
		send_sample(4'd1, 2'd0, 10'h3FF, 10'h3FF, 12'd0, 9'h1FF, 13'd0, '0, '0, 16'd30, 0);
		send_sample(4'd1, 2'd2, 10'd0, 10'd0, 12'd0, 9'd0, 13'd0, '0, '0, '0, 2);
		send_sample(4'd1, 2'd3, 10'd1000, 10'd1000, 12'hFFF, 9'd359, 13'h1FFF,
			15'h7FFF, 15'h7FFF, 16'hFFFF, 0);
		send_sample(4'd1, 2'd1, 10'd500, 10'd500, 12'd0, 9'd90, 13'd1850, '0, '0, 16'd33, 0);
		send_sample(4'd1, 2'd1, 10'd0, 10'd1000, 12'd0, 9'd0, 13'd0,
			-15'sd11520, 15'sd11520, 16'd50, 0);
		send_sample(4'd1, 2'd1, 10'd1000, 10'd0, 12'd0, 9'd359, 13'h1FFF,
			15'sd5760, -15'sd5760, 16'hFFFF, 0);
		send_sample(4'd2, 2'd0, 10'h3FF, 10'h3FF, 12'd0, 9'h1FF, 13'd0,
			15'h4000, 15'h3FFF, 16'd20, 0);
		send_sample(4'hF, 2'd2, 10'd0, 10'd0, 12'd0, 9'd0, 13'd0,
			15'sd2880, -15'sd8640, 16'd0, 3);
		send_sample(4'hF, 2'd3, 10'd250, 10'd750, 12'd0, 9'd180, 13'd500,
			15'sd23, -15'sd17, 16'd1000, 0);
		drain();

		random_phase(RANDOM_WORDS / 3);

		// extremes: all registers at full scale
		for (int r = REG_GAIN_X; r <= REG_PLANAR_LIM; r++)
			write_reg(3'(r), 24'hFFFFFF);
		random_phase(RANDOM_WORDS / 6);

		// all zero
		for (int r = REG_GAIN_X; r <= REG_PLANAR_LIM; r++)
			write_reg(3'(r), 24'd0);
		random_phase(RANDOM_WORDS / 12);

		// random settings, mostly moderate gains
		repeat (3) begin
			write_reg(REG_GAIN_X, 24'($urandom_range(0, 20000)));
			write_reg(REG_GAIN_Y, 24'($urandom_range(0, 20000)));
			write_reg(REG_GAIN_TIME, 24'($urandom_range(0, 400000)));
			write_reg(REG_GAIN_Z, 24'($urandom));
			write_reg(REG_GAIN_YAW, 24'($urandom_range(0, 1000000)));
			write_reg(REG_ALT_TARGET, 24'($urandom));
			write_reg(REG_PLANAR_LIM, 24'($urandom));
			random_phase(RANDOM_WORDS / 7);
		end

		if (fail_count == 0)
			$display("tb_tag_tracking_velocity_controller_core: done, clean");
		else
			$display("tb_tag_tracking_velocity_controller_core: done, errors");
		$finish;
	end
endmodule
